### rtl/core/i2ccl_pkg.sv
// Package of the I2C command list master: register map, flag bits,
// engine phase codes, slot opcodes, configuration indexes and default sizes.
// No dependencies.
package i2ccl_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned DefCommandSlots = 16;
  localparam int unsigned DefFifoDepth    = 32;

  // Item operations.
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Register word offsets.
  localparam logic [5:0] REG_CONTROL   = 6'd1;
  localparam logic [5:0] REG_FIFO_CONF = 6'd6;
  localparam logic [5:0] REG_FIFO_DATA = 6'd7;
  localparam logic [5:0] REG_RAW       = 6'd8;
  localparam logic [5:0] REG_CLEAR     = 6'd9;
  localparam logic [5:0] REG_SLOT_BASE = 6'd22;

  // Control and FIFO configuration bits.
  localparam int unsigned GoBit      = 5;
  localparam int unsigned RxClearBit = 12;
  localparam int unsigned TxClearBit = 13;

  // Raw interrupt flags.
  localparam int unsigned FlagW = 13;
  localparam logic [FlagW-1:0] F_ARB     = 13'h0020;
  localparam logic [FlagW-1:0] F_DONE    = 13'h0080;
  localparam logic [FlagW-1:0] F_TIMEOUT = 13'h0100;
  localparam logic [FlagW-1:0] F_ACKERR  = 13'h0400;

  // Widths of slot words, timing registers and the stretch counter.
  localparam int unsigned SlotW    = 14;
  localparam int unsigned PeriodW  = 14;
  localparam int unsigned StretchW = 20;
  localparam logic [StretchW-1:0] STRETCH_TOP = 20'hFFFFF;

  // Slot opcodes.
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_READ  = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_END   = 3'd4;

  // Engine phases.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_FETCH   = 4'd1;
  localparam logic [3:0] PH_S_LOW   = 4'd2;
  localparam logic [3:0] PH_S_RISE  = 4'd3;
  localparam logic [3:0] PH_S_SETUP = 4'd4;
  localparam logic [3:0] PH_S_HOLD  = 4'd5;
  localparam logic [3:0] PH_B_LOW   = 4'd6;
  localparam logic [3:0] PH_B_RISE  = 4'd7;
  localparam logic [3:0] PH_B_HIGH  = 4'd8;
  localparam logic [3:0] PH_P_LOW   = 4'd9;
  localparam logic [3:0] PH_P_RISE  = 4'd10;
  localparam logic [3:0] PH_P_SETUP = 4'd11;
  localparam logic [3:0] PH_P_HOLD  = 4'd12;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SCL_LOW    = 3'd0;
  localparam logic [2:0] CFG_SCL_HIGH   = 3'd1;
  localparam logic [2:0] CFG_SDA_HOLD   = 3'd2;
  localparam logic [2:0] CFG_SDA_SAMPLE = 3'd3;
  localparam logic [2:0] CFG_START_HOLD = 3'd4;
  localparam logic [2:0] CFG_SETUP      = 3'd5;
  localparam logic [2:0] CFG_STOP_HOLD  = 3'd6;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd7;

  // Source of the read data of a response.
  typedef enum logic [1:0] {
    ANS_DIRECT = 2'd0,
    ANS_SLOT   = 2'd1,
    ANS_RX     = 2'd2
  } ans_sel_e;

endpackage

### rtl/core/i2c_command_list_master.sv
// Top level of the I2C command list master: engine, command slot memory
// and both byte FIFO memories. Uses i2ccl_pkg.
//
// Usage: each request on the input channel is a clock tick (with sampled
// SDA and SCL levels), a register write or a register read. Every request
// gives exactly one response on the output channel, holding the read data
// and the line drive and busy state after the request.
// The response is registered: a request accepted at one edge shows its response
// in the next cycle. Throughput is one request per cycle; the slot,
// TX and RX memories each serve one write and their reads per cycle, and
// the engine keeps the current slot word and the TX head byte prefetched
// in the memories' read registers, forwarding a write to the same entry.
// When the receiver stalls, the response holds and the input takes a new
// request only in the cycle the held response is taken.
// Reset clears the slots through per-slot valid bits, empties both FIFOs,
// clears the flags, idles the engine and releases both lines; no clearing
// pass is needed, so requests are taken right after reset.
// Timing registers are written on the configuration port; the user must write them
// only while the block is idle, which the block itself does not enforce.
module i2c_command_list_master
  import i2ccl_pkg::*;
#(
  parameter int unsigned COMMAND_SLOTS = DefCommandSlots,
  parameter int unsigned FIFO_DEPTH    = DefFifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic        sda_in_i,
  input  logic        scl_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        scl_pull_low_o,
  output logic        sda_pull_low_o,
  output logic        engine_busy_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_wdata_i
);

  localparam int unsigned SlotAw = (COMMAND_SLOTS > 1) ? $clog2(COMMAND_SLOTS) : 1;
  localparam int unsigned CurW   = $clog2(COMMAND_SLOTS + 1);
  localparam int unsigned FifoAw = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned LvlW   = $clog2(FIFO_DEPTH + 1);
  localparam logic [CurW-1:0]   SlotsC  = CurW'(COMMAND_SLOTS);
  localparam logic [LvlW-1:0]   DepthC  = LvlW'(FIFO_DEPTH);
  localparam logic [FifoAw-1:0] LastPos = FifoAw'(FIFO_DEPTH - 1);
  localparam logic [6:0]        SlotEnd = 7'(COMMAND_SLOTS) + 7'(REG_SLOT_BASE);

  // Configuration registers.
  logic [PeriodW-1:0]  cfg_low_q, cfg_high_q, cfg_hold_q, cfg_sample_q;
  logic [PeriodW-1:0]  cfg_start_q, cfg_setup_q, cfg_stop_q;
  logic [StretchW-1:0] cfg_timeout_q;

  // Engine and FIFO control state.
  logic [3:0]          phase_q, phase_d;
  logic [CurW-1:0]     cur_q, cur_d;
  logic [7:0]          bytes_q, bytes_d;
  logic [3:0]          bitpos_q, bitpos_d;
  logic [7:0]          shift_q, shift_d;
  logic [PeriodW-1:0]  period_q, period_d;
  logic [StretchW-1:0] stretch_q, stretch_d;
  logic                drv_scl_q, drv_scl_d, drv_sda_q, drv_sda_d;
  logic [FlagW-1:0]    flags_q, flags_d;
  logic [FifoAw-1:0]   tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [FifoAw-1:0]   rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [LvlW-1:0]     tx_lvl_q, tx_lvl_d, rx_lvl_q, rx_lvl_d;
  logic [COMMAND_SLOTS-1:0] slot_vld_q, slot_vld_d;

  // Response registers.
  logic        out_valid_q;
  ans_sel_e    ans_sel_q, ans_sel_d;
  logic [31:0] ans_q, ans_d;
  logic        slot_rd_vld_q;

  // Memories and their read registers.
  logic [SlotW-1:0] slot_mem [COMMAND_SLOTS];
  logic [7:0]       tx_mem [FIFO_DEPTH];
  logic [7:0]       rx_mem [FIFO_DEPTH];
  logic [SlotW-1:0] eng_rdata_q, slot_rd_q;
  logic [7:0]       tx_rdata_q, rx_rdata_q;

  // Memory access requests.
  logic              acc, slot_in_range;
  logic [SlotAw-1:0] slot_idx, eng_idx, eng_raddr;
  logic              slot_we, slot_re, tx_push, rx_pop, rx_we;
  logic [7:0]        rx_wdata;

  assign in_ready_o     = !out_valid_q || out_ready_i;
  assign acc            = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign scl_pull_low_o = drv_scl_q;
  assign sda_pull_low_o = drv_sda_q;
  assign engine_busy_o  = (phase_q != PH_IDLE);

  assign slot_in_range = (7'(reg_index_i) >= 7'(REG_SLOT_BASE)) && (7'(reg_index_i) < SlotEnd);
  assign slot_idx      = SlotAw'(reg_index_i - REG_SLOT_BASE);
  assign eng_idx       = (cur_q < SlotsC) ? SlotAw'(cur_q) : '0;
  assign eng_raddr     = (cur_d < SlotsC) ? SlotAw'(cur_d) : '0;

  // Read data of a response comes from a register or a memory read port.
  always_comb begin
    case (ans_sel_q)
      ANS_SLOT: read_data_o = slot_rd_vld_q ? 32'(slot_rd_q) : '0;
      ANS_RX:   read_data_o = 32'(rx_rdata_q);
      default:  read_data_o = ans_q;
    endcase
  end

  // Engine and register access, one request per cycle while the output is not stalled.
  always_comb begin
    logic [SlotW-1:0]   w;
    logic               rd, take, abort, pull;
    logic [2:0]         cmd;
    logic [7:0]         tx_byte, new_shift, bytes_dec;
    logic [PeriodW-1:0] hold_at, sample_at, hold_lim;

    phase_d    = phase_q;
    cur_d      = cur_q;
    bytes_d    = bytes_q;
    bitpos_d   = bitpos_q;
    shift_d    = shift_q;
    period_d   = period_q;
    stretch_d  = stretch_q;
    drv_scl_d  = drv_scl_q;
    drv_sda_d  = drv_sda_q;
    flags_d    = flags_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    tx_lvl_d   = tx_lvl_q;
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    rx_lvl_d   = rx_lvl_q;
    slot_vld_d = slot_vld_q;
    ans_sel_d  = ANS_DIRECT;
    ans_d      = '0;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    tx_push    = 1'b0;
    rx_pop     = 1'b0;
    rx_we      = 1'b0;
    rx_wdata   = shift_q;
    take       = 1'b0;
    abort      = 1'b0;
    new_shift  = {shift_q[6:0], sda_in_i};
    bytes_dec  = (bytes_q != 8'd0) ? bytes_q - 8'd1 : bytes_q;

    w         = slot_vld_q[eng_idx] ? eng_rdata_q : '0;
    cmd       = w[13:11];
    rd        = (cmd == CMD_READ);
    tx_byte   = (tx_lvl_q == '0) ? 8'hFF : tx_rdata_q;
    hold_at   = (cfg_hold_q < cfg_low_q) ? cfg_hold_q : cfg_low_q;
    sample_at = (cfg_sample_q < cfg_high_q) ? cfg_sample_q : cfg_high_q;
    hold_lim  = (phase_q == PH_S_HOLD) ? cfg_start_q : cfg_stop_q;

    // Bit driven in the low stage of a data or ACK bit.
    if (bitpos_q < 4'd8) begin
      pull = rd ? 1'b0 : !shift_q[~bitpos_q[2:0]];
    end else if (!rd) begin
      pull = 1'b0;
    end else begin
      pull = (bytes_q <= 8'd1) ? !w[10] : 1'b1;
    end

    if (acc && operation_i == OP_TICK) begin
      case (phase_q)
        PH_IDLE: begin
        end
        PH_FETCH: begin
          period_d = '0;
          if (cur_q >= SlotsC) begin
            flags_d = flags_q | F_DONE;
            phase_d = PH_IDLE;
          end else begin
            case (cmd)
              CMD_START: begin
                if (drv_scl_q) begin
                  phase_d = PH_S_LOW;
                end else begin
                  drv_sda_d = 1'b0;
                  phase_d   = PH_S_RISE;
                end
              end
              CMD_WRITE, CMD_READ: begin
                if (w[7:0] == 8'd0) begin
                  cur_d = cur_q + 1'b1;
                end else begin
                  bytes_d   = w[7:0];
                  bitpos_d  = '0;
                  take      = !rd;
                  shift_d   = rd ? 8'd0 : tx_byte;
                  drv_scl_d = 1'b1;
                  phase_d   = PH_B_LOW;
                end
              end
              CMD_STOP: begin
                drv_scl_d = 1'b1;
                phase_d   = PH_P_LOW;
              end
              default: begin
                flags_d = flags_q | F_DONE;
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
        PH_S_LOW, PH_B_LOW, PH_P_LOW: begin
          if (period_q == hold_at) begin
            if (phase_q == PH_S_LOW) begin
              drv_sda_d = 1'b0;
            end else if (phase_q == PH_P_LOW) begin
              drv_sda_d = 1'b1;
            end else begin
              drv_sda_d = pull;
            end
          end
          if (period_q == cfg_low_q) begin
            drv_scl_d = 1'b0;
            phase_d   = phase_q + 4'd1;
            period_d  = '0;
          end else begin
            period_d = period_q + 1'b1;
          end
        end
        PH_S_RISE, PH_B_RISE, PH_P_RISE: begin
          // Wait while a slave stretches SCL low.
          if (!scl_in_i) begin
            if (stretch_q >= cfg_timeout_q) begin
              flags_d = flags_q | F_TIMEOUT;
            end else if (stretch_q != STRETCH_TOP) begin
              stretch_d = stretch_q + 1'b1;
            end
          end else begin
            stretch_d = '0;
            period_d  = '0;
            phase_d   = phase_q + 4'd1;
          end
        end
        PH_S_SETUP, PH_P_SETUP: begin
          if (period_q == cfg_setup_q) begin
            drv_sda_d = (phase_q == PH_S_SETUP);
            phase_d   = phase_q + 4'd1;
            period_d  = '0;
          end else begin
            period_d = period_q + 1'b1;
          end
        end
        PH_S_HOLD, PH_P_HOLD: begin
          if (period_q == hold_lim) begin
            if (phase_q == PH_S_HOLD) begin
              drv_scl_d = 1'b1;
            end
            cur_d   = cur_q + 1'b1;
            phase_d = PH_FETCH;
          end else begin
            period_d = period_q + 1'b1;
          end
        end
        PH_B_HIGH: begin
          // Sample the data or ACK bit, checking arbitration and ACK.
          if (period_q == sample_at) begin
            if (bitpos_q < 4'd8) begin
              if (rd) begin
                shift_d = new_shift;
                if (bitpos_q == 4'd7 && rx_lvl_q < DepthC) begin
                  rx_we     = 1'b1;
                  rx_wdata  = new_shift;
                  rx_tail_d = (rx_tail_q == LastPos) ? '0 : rx_tail_q + 1'b1;
                  rx_lvl_d  = rx_lvl_q + 1'b1;
                end
              end else if (shift_q[~bitpos_q[2:0]] && !sda_in_i) begin
                abort   = 1'b1;
                flags_d = flags_q | F_ARB;
              end
            end else if (!rd && w[8] && (sda_in_i != w[9])) begin
              abort   = 1'b1;
              flags_d = flags_q | F_ACKERR;
            end
          end
          if (abort) begin
            drv_scl_d = 1'b0;
            drv_sda_d = 1'b0;
            phase_d   = PH_IDLE;
          end else if (period_q != cfg_high_q) begin
            period_d = period_q + 1'b1;
          end else begin
            drv_scl_d = 1'b1;
            period_d  = '0;
            phase_d   = PH_B_LOW;
            if (bitpos_q < 4'd8) begin
              bitpos_d = bitpos_q + 4'd1;
            end else begin
              bytes_d = bytes_dec;
              if (bytes_dec == 8'd0) begin
                cur_d   = cur_q + 1'b1;
                phase_d = PH_FETCH;
              end else begin
                bitpos_d = '0;
                take     = !rd;
                shift_d  = rd ? 8'd0 : tx_byte;
              end
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end else if (acc && operation_i == OP_WRITE) begin
      case (reg_index_i)
        REG_CONTROL: begin
          if (write_data_i[GoBit] && phase_q == PH_IDLE) begin
            cur_d     = '0;
            period_d  = '0;
            stretch_d = '0;
            phase_d   = PH_FETCH;
          end
        end
        REG_FIFO_CONF: begin
          if (write_data_i[RxClearBit]) begin
            rx_head_d = '0;
            rx_tail_d = '0;
            rx_lvl_d  = '0;
          end
          if (write_data_i[TxClearBit]) begin
            tx_head_d = '0;
            tx_tail_d = '0;
            tx_lvl_d  = '0;
          end
        end
        REG_FIFO_DATA: begin
          if (tx_lvl_q < DepthC) begin
            tx_push   = 1'b1;
            tx_tail_d = (tx_tail_q == LastPos) ? '0 : tx_tail_q + 1'b1;
            tx_lvl_d  = tx_lvl_q + 1'b1;
          end
        end
        REG_CLEAR: flags_d = flags_q & ~write_data_i[FlagW-1:0];
        default: begin
          if (slot_in_range) begin
            slot_we              = 1'b1;
            slot_vld_d[slot_idx] = 1'b1;
          end
        end
      endcase
    end else if (acc && operation_i == OP_READ) begin
      case (reg_index_i)
        REG_CONTROL: ans_d = 32'(phase_q != PH_IDLE) << GoBit;
        REG_FIFO_DATA: begin
          if (rx_lvl_q != '0) begin
            rx_pop    = 1'b1;
            ans_sel_d = ANS_RX;
            rx_head_d = (rx_head_q == LastPos) ? '0 : rx_head_q + 1'b1;
            rx_lvl_d  = rx_lvl_q - 1'b1;
          end
        end
        REG_RAW: ans_d = 32'(flags_q);
        default: begin
          if (slot_in_range) begin
            slot_re   = 1'b1;
            ans_sel_d = ANS_SLOT;
          end
        end
      endcase
    end

    // Pop of the transmit FIFO head byte.
    if (take && tx_lvl_q != '0) begin
      tx_head_d = (tx_head_q == LastPos) ? '0 : tx_head_q + 1'b1;
      tx_lvl_d  = tx_lvl_q - 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_low_q     <= 14'd399;
      cfg_high_q    <= 14'd399;
      cfg_hold_q    <= 14'd200;
      cfg_sample_q  <= 14'd200;
      cfg_start_q   <= 14'd400;
      cfg_setup_q   <= 14'd400;
      cfg_stop_q    <= 14'd400;
      cfg_timeout_q <= STRETCH_TOP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCL_LOW:    cfg_low_q     <= cfg_wdata_i[PeriodW-1:0];
        CFG_SCL_HIGH:   cfg_high_q    <= cfg_wdata_i[PeriodW-1:0];
        CFG_SDA_HOLD:   cfg_hold_q    <= cfg_wdata_i[PeriodW-1:0];
        CFG_SDA_SAMPLE: cfg_sample_q  <= cfg_wdata_i[PeriodW-1:0];
        CFG_START_HOLD: cfg_start_q   <= cfg_wdata_i[PeriodW-1:0];
        CFG_SETUP:      cfg_setup_q   <= cfg_wdata_i[PeriodW-1:0];
        CFG_STOP_HOLD:  cfg_stop_q    <= cfg_wdata_i[PeriodW-1:0];
        CFG_TIMEOUT:    cfg_timeout_q <= cfg_wdata_i[StretchW-1:0];
        default: cfg_timeout_q <= cfg_timeout_q;
      endcase
    end
  end

  // Engine, FIFO pointer and response control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cur_q       <= '0;
      bytes_q     <= '0;
      bitpos_q    <= '0;
      shift_q     <= '0;
      period_q    <= '0;
      stretch_q   <= '0;
      drv_scl_q   <= 1'b0;
      drv_sda_q   <= 1'b0;
      flags_q     <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      tx_lvl_q    <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      rx_lvl_q    <= '0;
      slot_vld_q  <= '0;
      out_valid_q <= 1'b0;
      ans_sel_q   <= ANS_DIRECT;
    end else begin
      phase_q     <= phase_d;
      cur_q       <= cur_d;
      bytes_q     <= bytes_d;
      bitpos_q    <= bitpos_d;
      shift_q     <= shift_d;
      period_q    <= period_d;
      stretch_q   <= stretch_d;
      drv_scl_q   <= drv_scl_d;
      drv_sda_q   <= drv_sda_d;
      flags_q     <= flags_d;
      tx_head_q   <= tx_head_d;
      tx_tail_q   <= tx_tail_d;
      tx_lvl_q    <= tx_lvl_d;
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      rx_lvl_q    <= rx_lvl_d;
      slot_vld_q  <= slot_vld_d;
      out_valid_q <= acc || (out_valid_q && !out_ready_i);
      if (acc) begin
        ans_sel_q <= ans_sel_d;
      end
    end
  end

  // Direct read data of a response.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      ans_q <= ans_d;
    end
  end

  // Command slot memory: engine port follows the next slot, with write forwarding.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_idx] <= write_data_i[SlotW-1:0];
    end
    if (slot_we && slot_idx == eng_raddr) begin
      eng_rdata_q <= write_data_i[SlotW-1:0];
    end else begin
      eng_rdata_q <= slot_mem[eng_raddr];
    end
    if (slot_re) begin
      slot_rd_q     <= slot_mem[slot_idx];
      slot_rd_vld_q <= slot_vld_q[slot_idx];
    end
  end

  // Transmit FIFO memory: the head byte stays prefetched.
  always_ff @(posedge clk_i) begin
    if (tx_push) begin
      tx_mem[tx_tail_q] <= write_data_i[7:0];
    end
    if (tx_push && tx_tail_q == tx_head_d) begin
      tx_rdata_q <= write_data_i[7:0];
    end else begin
      tx_rdata_q <= tx_mem[tx_head_d];
    end
  end

  // Receive FIFO memory.
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_tail_q] <= rx_wdata;
    end
    if (rx_pop) begin
      rx_rdata_q <= rx_mem[rx_head_q];
    end
  end

endmodule

### rtl/core/i2ccl_checker.sv
// Port checker of the I2C command list master, bound to the top level.
// Depends on i2c_command_list_master.
module i2ccl_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic        scl_pull_low_o,
  input logic        sda_pull_low_o,
  input logic        engine_busy_o
);

  // A held response keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("response changed while stalled");

  // The engine starts only on a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(engine_busy_o) |-> $past(in_valid_i && in_ready_o))
    else $error("engine started without a request");

  // Line drive changes only on a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(scl_pull_low_o) || !$stable(sda_pull_low_o)
      |-> $past(in_valid_i && in_ready_o))
    else $error("line drive changed without a request");

  // A new response appears only after a request was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("response without a request");

  // With no response pending, a request is always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind i2c_command_list_master i2ccl_port_checker u_i2ccl_port_checker (.*);
